FILE: hdl/capture_record_to_pcap_rewriter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capture record rewriter
// Shared property forms. Every macro samples on clk and is held off in rst.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_RECORD_TO_PCAP_REWRITER_TOP_DEFINES_SVH
`define CAPTURE_RECORD_TO_PCAP_REWRITER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CRPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crpr check failed");

// Next-cycle implication.
`define CRPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crpr check failed");

`endif

FILE: hdl/crpr_pkg.sv
// ----------------------------------------------------------------------------
// crpr_pkg
// Types and constants shared by the capture record rewriter modules.
// ----------------------------------------------------------------------------
package crpr_pkg;

  // chunk and record geometry
  localparam int unsigned CHUNK_BYTES = 262144;
  localparam int CHUNK_CNT_W = $clog2(CHUNK_BYTES);
  localparam int HDR_BYTES   = 16;
  localparam int DATA_BYTES  = HDR_BYTES - 1;   // last header byte is pad, never kept
  localparam int HPOS_W      = $clog2(HDR_BYTES);
  localparam int COUNT_W     = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // timestamp split by 10^9
  localparam int REM_W = 30;
  localparam logic [REM_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam int TS_W           = 64;
  localparam int TS_HI_W        = 29;           // 2^29 < 10^9: no quotient bits up here
  localparam int DIV_LOW_BITS   = TS_W - TS_HI_W;
  localparam int DIV_RADIX_BITS = 5;
  localparam int DIV_STEPS      = DIV_LOW_BITS / DIV_RADIX_BITS;
  localparam int DIV_STEP_W     = $clog2(DIV_STEPS);

  // request queue between front and back
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_CONVERT,
    CMD_CUT
  } cmd_kind_t;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  typedef logic [DATA_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               last_of_run;
    logic               chunk_done;
    logic [COUNT_W-1:0] record_count;
    logic               truncated;
  } out_item_t;

  // one request per input byte that yields output
  typedef struct packed {
    cmd_kind_t          kind;
    hdr_bytes_t         data;     // pass byte in element 0, else header bytes
    logic [HPOS_W-1:0]  nbytes;   // bytes held for a cut header
    logic               done;     // closes the chunk
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] sec;
    logic [31:0] nsec;
  } job_t;

endpackage

FILE: hdl/capture_record_to_pcap_rewriter_top.sv
// ----------------------------------------------------------------------------
// capture_record_to_pcap_rewriter_top
// Throughput: 1 byte/cycle while the request queue is not full; each header
// holds the back end in the divider, so short records fill the request queue and
// push waits. Reset: sync, no clear pass.
// ----------------------------------------------------------------------------
module capture_record_to_pcap_rewriter_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  crpr_pkg::in_item_t   item,
  output logic                 empty,
  input  logic                 pop,
  output crpr_pkg::out_item_t  result
);

  // Front: parses the byte stream into records. Header bytes are held; a
  // byte that finishes a header, a payload byte, or a chunk end inside a
  // header becomes one request. Chunk end (flag or byte limit) clears state.
  logic            accept;
  logic            q_push, q_full, q_empty, q_pop;
  crpr_pkg::cmd_t  q_wdata, q_rdata;

  assign accept = push && !q_full;
  assign full   = q_full;

  crpr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // Request queue: absorbs the divider latency so input keeps flowing while
  // a converted header is still being emitted.
  crpr_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back end, stage one: timestamp / 10^9 for header requests, a registered
  // hop for everything else. Order of requests is kept.
  logic            slot_valid, slot_take;
  crpr_pkg::job_t  slot;

  crpr_div u_div (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .slot_valid (slot_valid),
    .slot       (slot),
    .slot_take  (slot_take)
  );

  // Back end, stage two: one result byte per pop; a new job loads in the
  // same cycle the last byte of the previous one is popped.
  crpr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (slot_valid),
    .job       (slot),
    .job_take  (slot_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

FILE: hdl/crpr_front.sv
// ----------------------------------------------------------------------------
// crpr_front
// Record parser: holds header bytes, tracks payload and chunk, issues requests.
// ----------------------------------------------------------------------------
module crpr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  crpr_pkg::in_item_t  item,
  output logic                q_push,
  output crpr_pkg::cmd_t      q_data
);

  logic [7:0]                         store [crpr_pkg::DATA_BYTES];
  logic [crpr_pkg::HPOS_W-1:0]        hpos, hpos_next;
  logic [15:0]                        pay_rem, pay_rem_next;
  logic                               in_payload, in_payload_next;
  logic [crpr_pkg::COUNT_W-1:0]       records, records_next;
  logic [crpr_pkg::CHUNK_CNT_W-1:0]   chunk_cnt;
  crpr_pkg::hdr_bytes_t               hdr_view;
  logic [15:0]                        cap;
  logic                               last, complete, cmd_valid;

  // header as it stands with the current byte merged in
  always_comb begin
    for (int i = 0; i < crpr_pkg::DATA_BYTES; i++) begin
      hdr_view[i] = (hpos == crpr_pkg::HPOS_W'(i)) ? item.in_byte : store[i];
    end
  end

  assign cap      = {hdr_view[9], hdr_view[8]};
  assign last     = item.chunk_last ||
                    (chunk_cnt == crpr_pkg::CHUNK_CNT_W'(crpr_pkg::CHUNK_BYTES - 1));
  assign complete = !in_payload && (hpos == crpr_pkg::HPOS_W'(crpr_pkg::HDR_BYTES - 1));

  always_comb begin
    hpos_next       = hpos;
    pay_rem_next    = pay_rem;
    in_payload_next = in_payload;
    records_next    = records;
    cmd_valid       = 1'b0;
    q_data          = '0;
    q_data.kind     = crpr_pkg::CMD_PASS;
    q_data.data[0]  = item.in_byte;
    q_data.done     = last;
    if (in_payload) begin
      cmd_valid       = 1'b1;
      pay_rem_next    = pay_rem - 16'd1;
      in_payload_next = (pay_rem != 16'd1);
    end else if (complete) begin
      cmd_valid       = 1'b1;
      q_data.kind     = crpr_pkg::CMD_CONVERT;
      q_data.data     = hdr_view;
      hpos_next       = '0;
      if (records != crpr_pkg::COUNT_MAX) begin
        records_next = records + 1'b1;
      end
      pay_rem_next    = cap;
      in_payload_next = (cap != 16'd0);
    end else begin
      hpos_next = hpos + 1'b1;
      if (last) begin
        cmd_valid     = 1'b1;
        q_data.kind   = crpr_pkg::CMD_CUT;
        q_data.data   = hdr_view;
        q_data.nbytes = hpos + 1'b1;
      end
    end
    q_data.count = records_next;
    // chunk end drops everything
    if (last) begin
      hpos_next       = '0;
      pay_rem_next    = '0;
      in_payload_next = 1'b0;
      records_next    = '0;
    end
  end

  assign q_push = accept && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hpos       <= '0;
      pay_rem    <= '0;
      in_payload <= 1'b0;
      records    <= '0;
      chunk_cnt  <= '0;
    end else if (accept) begin
      hpos       <= hpos_next;
      pay_rem    <= pay_rem_next;
      in_payload <= in_payload_next;
      records    <= records_next;
      chunk_cnt  <= last ? '0 : chunk_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_payload && !complete) begin
      store[hpos] <= item.in_byte;
    end
  end

endmodule

FILE: hdl/crpr_fifo.sv
// ----------------------------------------------------------------------------
// crpr_fifo
// Request queue between parser and back end; first word shown while not empty.
// ----------------------------------------------------------------------------
module crpr_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  crpr_pkg::cmd_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output crpr_pkg::cmd_t  rd_data,
  output logic            empty
);

  crpr_pkg::cmd_t               slots [crpr_pkg::FIFO_DEPTH];
  logic [crpr_pkg::FIFO_AW-1:0] wptr, rptr;
  logic [crpr_pkg::FIFO_AW:0]   cnt;

  assign full    = (cnt == (crpr_pkg::FIFO_AW + 1)'(crpr_pkg::FIFO_DEPTH));
  assign empty   = (cnt == '0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/crpr_div.sv
// ----------------------------------------------------------------------------
// crpr_div
// Back end stage one: splits the timestamp into seconds and nanoseconds,
// five quotient bits per cycle; other requests pass straight to the slot.
// ----------------------------------------------------------------------------
module crpr_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  crpr_pkg::cmd_t  q_data,
  output logic            q_pop,
  output logic            slot_valid,
  output crpr_pkg::job_t  slot,
  input  logic            slot_take
);

  crpr_pkg::div_state_t                state, state_next;
  crpr_pkg::cmd_t                      work;
  logic [crpr_pkg::REM_W-1:0]          rem, rem_step;
  logic [crpr_pkg::DIV_LOW_BITS-1:0]   dvd;
  logic [31:0]                         quo, quo_step;
  logic [crpr_pkg::DIV_STEP_W-1:0]     step;
  logic [crpr_pkg::TS_W-1:0]           ts;
  logic                                load_work, adv, slot_load, slot_free;
  crpr_pkg::job_t                      slot_in;

  assign ts        = q_data.data[7:0];
  assign slot_free = !slot_valid || slot_take;

  // one radix-32 digit: five restoring compare/subtract steps
  always_comb begin
    logic [crpr_pkg::REM_W-1:0]          r;
    logic [crpr_pkg::REM_W:0]            t;
    logic [crpr_pkg::DIV_RADIX_BITS-1:0] qd;
    r  = rem;
    qd = '0;
    for (int j = 0; j < crpr_pkg::DIV_RADIX_BITS; j++) begin
      t = {r, dvd[crpr_pkg::DIV_LOW_BITS-1-j]};
      if (t >= {1'b0, crpr_pkg::NS_PER_SEC}) begin
        r = crpr_pkg::REM_W'(t - {1'b0, crpr_pkg::NS_PER_SEC});
        qd[crpr_pkg::DIV_RADIX_BITS-1-j] = 1'b1;
      end else begin
        r = t[crpr_pkg::REM_W-1:0];
      end
    end
    rem_step = r;
    quo_step = {quo[31-crpr_pkg::DIV_RADIX_BITS:0], qd};
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_work  = 1'b0;
    adv        = 1'b0;
    slot_load  = 1'b0;
    slot_in    = '0;
    unique case (state)
      crpr_pkg::DIV_IDLE: begin
        if (!q_empty) begin
          if (q_data.kind == crpr_pkg::CMD_CONVERT) begin
            q_pop      = 1'b1;
            load_work  = 1'b1;
            state_next = crpr_pkg::DIV_RUN;
          end else if (slot_free) begin
            q_pop       = 1'b1;
            slot_load   = 1'b1;
            slot_in.cmd = q_data;
          end
        end
      end
      crpr_pkg::DIV_RUN: begin
        if (step != crpr_pkg::DIV_STEP_W'(crpr_pkg::DIV_STEPS - 1)) begin
          adv = 1'b1;
        end else if (slot_free) begin
          slot_load    = 1'b1;
          slot_in.cmd  = work;
          slot_in.sec  = quo_step;
          slot_in.nsec = 32'(rem_step);
          state_next   = crpr_pkg::DIV_IDLE;
        end
      end
      default: state_next = crpr_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= crpr_pkg::DIV_IDLE;
      slot_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (slot_load) begin
        slot_valid <= 1'b1;
      end else if (slot_take) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_work) begin
      work <= q_data;
      rem  <= crpr_pkg::REM_W'(ts[crpr_pkg::TS_W-1:crpr_pkg::DIV_LOW_BITS]);
      dvd  <= ts[crpr_pkg::DIV_LOW_BITS-1:0];
      quo  <= '0;
      step <= '0;
    end else if (adv) begin
      rem  <= rem_step;
      dvd  <= dvd << crpr_pkg::DIV_RADIX_BITS;
      quo  <= quo_step;
      step <= step + 1'b1;
    end
    if (slot_load) begin
      slot <= slot_in;
    end
  end

endmodule

FILE: hdl/crpr_emit.sv
// ----------------------------------------------------------------------------
// crpr_emit
// Back end stage two: holds one job and walks its output bytes.
// ----------------------------------------------------------------------------
module crpr_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  crpr_pkg::job_t       job,
  output logic                 job_take,
  output logic                 empty,
  input  logic                 pop,
  output crpr_pkg::out_item_t  result
);

  crpr_pkg::job_t               cur;
  logic                         busy;
  logic [crpr_pkg::HPOS_W-1:0]  idx, n_last;
  logic [31:0]                  word, shifted;
  logic [7:0]                   byte_sel;
  logic                         is_last, fin, closing;

  // PCAP words: seconds, nanoseconds, captured length, wire length
  always_comb begin
    unique case (idx[3:2])
      2'd0:    word = cur.sec;
      2'd1:    word = cur.nsec;
      2'd2:    word = {16'b0, cur.cmd.data[9:8]};
      default: word = {16'b0, cur.cmd.data[11:10]};
    endcase
    shifted = word >> {idx[1:0], 3'b000};
  end

  always_comb begin
    unique case (cur.cmd.kind)
      crpr_pkg::CMD_CONVERT: begin
        byte_sel = shifted[7:0];
        n_last   = crpr_pkg::HPOS_W'(crpr_pkg::HDR_BYTES - 1);
      end
      crpr_pkg::CMD_CUT: begin
        byte_sel = cur.cmd.data[idx];
        n_last   = cur.cmd.nbytes - 1'b1;
      end
      default: begin
        byte_sel = cur.cmd.data[0];
        n_last   = '0;
      end
    endcase
  end

  assign is_last  = (idx == n_last);
  assign closing  = is_last && cur.cmd.done;
  assign fin      = pop && busy && is_last;
  assign job_take = job_valid && (!busy || fin);
  assign empty    = !busy;

  always_comb begin
    result.out_byte     = byte_sel;
    result.last_of_run  = is_last;
    result.chunk_done   = closing;
    result.record_count = closing ? cur.cmd.count : '0;
    result.truncated    = closing && (cur.cmd.kind == crpr_pkg::CMD_CUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (job_take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fin) begin
      busy <= 1'b0;
    end else if (pop && busy) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
  end

endmodule

FILE: hdl/crpr_checker.sv
// ----------------------------------------------------------------------------
// crpr_checker
// Port-level checks on the rewriter, bound to the top level.
// ----------------------------------------------------------------------------
`include "capture_record_to_pcap_rewriter_top_defines.svh"

module crpr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input crpr_pkg::out_item_t  result
);

  logic tail_clear;

  assign tail_clear = (result.record_count == '0) && !result.truncated;

  // count and truncation only travel on the closing result
  `CRPR_ASSERT_NOW(a_tail_fields, !empty && !result.chunk_done, tail_clear)
  // the closing result ends its run
  `CRPR_ASSERT_NOW(a_done_is_last, !empty && result.chunk_done, result.last_of_run)
  // a waiting result holds
  `CRPR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))
  // out of reset with nothing queued
  `CRPR_ASSERT_NOW(a_reset_clean, $past(rst), empty && !full)

endmodule

bind capture_record_to_pcap_rewriter_top crpr_checker u_crpr_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
